// ===== rtl/quadratic_wavelength_calibration_unit_defines.svh =====
// Assertion macros for the wavelength calibration checkers
`ifndef QUADRATIC_WAVELENGTH_CALIBRATION_UNIT_DEFINES_SVH
`define QUADRATIC_WAVELENGTH_CALIBRATION_UNIT_DEFINES_SVH

// Same-cycle implication
`define QWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qwc assertion failed");

// Next-cycle implication
`define QWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qwc assertion failed");

`endif

// ===== rtl/qwc_pkg.sv =====
// Shared types, codes and helpers of the wavelength calibration unit
package qwc_pkg;

	// Input and result beats
	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] wave_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] wave_out;
		logic [1:0]         status;
	} out_item_t;

	// Operation codes
	localparam logic [1:0] MODE_BUILD = 2'd0;
	localparam logic [1:0] MODE_FWD   = 2'd1;
	localparam logic [1:0] MODE_INV   = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_PASS    = 2'd1;
	localparam logic [1:0] ST_BADCNT  = 2'd2;
	localparam logic [1:0] ST_NEGDISC = 2'd3;

	// Register indexes
	localparam logic [2:0] CFG_QUAD = 3'd0;
	localparam logic [2:0] CFG_LIN  = 3'd1;
	localparam logic [2:0] CFG_OFS  = 3'd2;
	localparam logic [2:0] CFG_MIN  = 3'd3;
	localparam logic [2:0] CFG_MAX  = 3'd4;

	localparam logic [31:0] LIN_RESET = 32'h0100_0000;

	// Datapath widths
	localparam int ACC_W  = 104;
	localparam int SQ_W   = 96;
	localparam int ROOT_W = SQ_W / 2;
	localparam int NB_W   = ROOT_W + 2;

	// Clamp a wide signed value to 32 bits
	function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
		if ((&v[ACC_W-1:31]) || (~|v[ACC_W-1:31])) begin
			return v[31:0];
		end else if (v[ACC_W-1]) begin
			return 32'h8000_0000;
		end else begin
			return 32'h7FFF_FFFF;
		end
	endfunction

endpackage

// ===== rtl/qwc_isqrt.sv =====
// Bit-serial floor integer square root, two radicand bits per cycle
module qwc_isqrt #(
	parameter int RAD_W = 96
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RAD_W-1:0]   radicand,
	output logic               done,
	output logic [RAD_W/2-1:0] root
);
	localparam int RT_W  = RAD_W / 2;
	localparam int REM_W = RT_W + 3;
	localparam int CNT_W = $clog2(RT_W + 1);

	logic [RAD_W-1:0] rad_q;
	logic [RT_W-1:0]  root_q;
	logic [REM_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;

	logic [REM_W-1:0] rem_sh, trial;
	logic             ge;

	// One restoring step
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
		trial  = REM_W'({root_q, 2'b01});
		ge     = rem_sh >= trial;
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(RT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			root_q <= {root_q[RT_W-2:0], ge};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ===== rtl/qwc_udiv.sv =====
// Bit-serial restoring unsigned divider, one quotient bit per cycle
module qwc_udiv #(
	parameter int NUM_W = 68,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q, rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;

	logic [DEN_W:0] rem_sh, rem_nx;
	logic           ge;

	// Shift in one dividend bit and try the subtract
	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath: the dividend register fills with quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= rem_nx[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;
endmodule

// ===== rtl/quadratic_wavelength_calibration_unit.sv =====
// Quadratic wavelength calibration with an interpolated inverse table
//
// Input channel in_valid/in_stall/in_data carries one beat per conversion: mode and
// a signed Q16.16 wavelength. Result channel out_valid/out_stall/out_data returns
// exactly one beat per input beat, in order. Registers are written on cfg_we with
// cfg_index/cfg_data; the user must write them only while the unit is idle; the block does not enforce it.
// One item is processed at a time; in_stall is high while an item is in work.
// Work per mode:
//   pass-through or bad table count: straight to the output step
//   mode 1: quadratic evaluation, 33x33 multiplier reused four times
//   mode 2: two single-port table reads, one multiply
//   mode 0 rebuild: per entry a direct write when the quadratic term is zero,
//   otherwise a square root and a divide.
// The result waits in an output register; the next input beat is taken while it
// is stalled, and that item then holds in its last step until the register frees.
// Reset clears the registers to their defaults and marks no table built, so modes
// 1 and 2 pass through until a rebuild with a good table count completes. The table memory itself is not
// cleared; a rebuild writes every entry it later reads.
module quadratic_wavelength_calibration_unit import qwc_pkg::*; #(
	parameter int TABLE_DEPTH = 2048,
	parameter int FRAC_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = NB_W + FRAC_BITS + 2;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_OUT    = 5'd1;
	localparam logic [4:0] S_E0     = 5'd2;
	localparam logic [4:0] S_E1     = 5'd3;
	localparam logic [4:0] S_E2     = 5'd4;
	localparam logic [4:0] S_E3     = 5'd5;
	localparam logic [4:0] S_E4     = 5'd6;
	localparam logic [4:0] S_E5     = 5'd7;
	localparam logic [4:0] S_R0     = 5'd8;
	localparam logic [4:0] S_R1     = 5'd9;
	localparam logic [4:0] S_R2     = 5'd10;
	localparam logic [4:0] S_R3     = 5'd11;
	localparam logic [4:0] S_R4     = 5'd12;
	localparam logic [4:0] S_BSTART = 5'd13;
	localparam logic [4:0] S_BP     = 5'd14;
	localparam logic [4:0] S_BT0    = 5'd15;
	localparam logic [4:0] S_BT1    = 5'd16;
	localparam logic [4:0] S_BD     = 5'd17;
	localparam logic [4:0] S_BSQ    = 5'd18;
	localparam logic [4:0] S_BDV    = 5'd19;
	localparam logic [4:0] S_BNEXT  = 5'd20;

	// Control state
	logic [4:0]         state_q;
	logic               out_valid_q;
	logic signed [31:0] quad_q, lin_q, ofs_q;
	logic [15:0]        min_q, max_q;
	logic [CW-1:0]      entry_count_q, cnt_q;
	logic               table_ready_q, neg_seen_q;
	logic [AW-1:0]      i_q;
	logic [15:0]        w_q;

	// Payload state
	out_item_t              out_q;
	logic signed [31:0]     win_q;
	logic [15:0]            idx_q;
	logic [FRAC_BITS-1:0]   frac_q;
	logic [63:0]            aw_q, cmw_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [65:0]     prod_q;
	logic [31:0]            y0_q, rd_q, res_q;
	logic signed [32:0]     dy_q;
	logic [1:0]             status_q;
	logic                   nneg_q;

	// Table memory
	logic [31:0] mem [TABLE_DEPTH];

	logic                    in_take, out_load, a_zero, a_neg;
	logic                    cnt_bad, in_range, idx_ok, last_entry;
	logic signed [63:0]      win64, lo64, hi64, diff64;
	logic [16:0]             span;
	logic [15:0]             idx_w, idx_nx;
	logic [FRAC_BITS-1:0]    frac_w;
	logic [AW-1:0]           mem_addr;
	logic                    mem_we, mem_re;
	logic [31:0]             wr_data, a_mag;
	logic signed [32:0]      mul_x, mul_y;
	logic signed [ACC_W-1:0] prod_ext, c_ext, wf_ext, q_abs, q_ext, v_ext;
	logic signed [65:0]      prod_rnd, prod_trn;
	logic [63:0]             wf64;
	logic signed [NB_W-1:0]  n_pre;
	logic signed [NW-1:0]    n_sh;
	logic [NW-1:0]           n_mag, dv_quo;
	logic                    sq_start, sq_done, dv_start, dv_done;
	logic [ROOT_W-1:0]       sq_root;

	// Handshakes
	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Range check and table index of the incoming wavelength
	always_comb begin
		win64    = {{32{in_data.wave_in[31]}}, in_data.wave_in};
		lo64     = 64'({min_q, {FRAC_BITS{1'b0}}});
		hi64     = 64'({max_q, {FRAC_BITS{1'b0}}});
		diff64   = win64 - lo64;
		in_range = table_ready_q && (win64 >= lo64) && (win64 <= hi64);
		idx_w    = diff64[FRAC_BITS+15:FRAC_BITS];
		frac_w   = diff64[FRAC_BITS-1:0];
		idx_ok   = (17'(idx_w) + 17'd1) < 17'(entry_count_q);
		span     = {1'b0, max_q} - {1'b0, min_q};
		cnt_bad  = (max_q < min_q) || (span >= 17'(TABLE_DEPTH));
		idx_nx   = idx_q + 16'd1;
		last_entry = (CW'(i_q) + CW'(1)) == cnt_q;
		a_zero   = (quad_q == '0);
		a_neg    = quad_q[31];
		a_mag    = a_neg ? (~quad_q + 32'd1) : quad_q;
	end

	// Wide operands
	always_comb begin
		prod_ext = {{(ACC_W-66){prod_q[65]}}, prod_q};
		c_ext    = {{(ACC_W-32){ofs_q[31]}}, ofs_q};
		wf64     = 64'({w_q, {FRAC_BITS{1'b0}}});
		wf_ext   = ACC_W'(wf64);
		// root - 8b, scaled up before the divide
		n_pre    = $signed({2'b00, sq_root}) - $signed({{(NB_W-35){lin_q[31]}}, lin_q, 3'b000});
		n_sh     = $signed({{(NW-NB_W){n_pre[NB_W-1]}}, n_pre}) <<< (FRAC_BITS + 2);
		n_mag    = n_sh[NW-1] ? (~n_sh + 1'b1) : n_sh;
		q_abs    = ACC_W'(dv_quo);
		q_ext    = (nneg_q != a_neg) ? -q_abs : q_abs;
		// interpolation product truncated toward zero
		prod_rnd = prod_q[65] ? (prod_q + {{(66-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}}) : prod_q;
		prod_trn = prod_rnd >>> FRAC_BITS;
		v_ext    = $signed({{(ACC_W-32){y0_q[31]}}, y0_q})
			+ $signed({{(ACC_W-66){prod_trn[65]}}, prod_trn});
	end

	// Shared multiplier operand select
	always_comb begin
		mul_x = '0;
		mul_y = '0;
		unique case (state_q)
			S_E0: begin
				mul_x = {quad_q[31], quad_q};
				mul_y = {win_q[31], win_q};
			end
			S_E1: begin
				mul_x = {lin_q[31], lin_q};
				mul_y = {win_q[31], win_q};
			end
			S_E2: begin
				mul_x = {1'b0, aw_q[31:0]};
				mul_y = {win_q[31], win_q};
			end
			S_E3: begin
				mul_x = {aw_q[63], aw_q[63:32]};
				mul_y = {win_q[31], win_q};
			end
			S_R3: begin
				mul_x = dy_q;
				mul_y = {{(33-FRAC_BITS){1'b0}}, frac_q};
			end
			S_BSTART: begin
				mul_x = {lin_q[31], lin_q};
				mul_y = {lin_q[31], lin_q};
			end
			S_BP: begin
				mul_x = {quad_q[31], quad_q};
				mul_y = {1'b0, cmw_q[31:0]};
			end
			S_BT0: begin
				mul_x = {quad_q[31], quad_q};
				mul_y = {cmw_q[63], cmw_q[63:32]};
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	// Table port and root/divide starts
	always_comb begin
		mem_we   = ((state_q == S_BSTART) && a_zero)
			|| ((state_q == S_BD) && acc_q[ACC_W-1])
			|| ((state_q == S_BDV) && dv_done);
		mem_re   = (state_q == S_R0) || (state_q == S_R1);
		sq_start = (state_q == S_BD) && !acc_q[ACC_W-1];
		dv_start = (state_q == S_BSQ) && sq_done;
		if (state_q == S_R0) begin
			mem_addr = idx_q[AW-1:0];
		end else if (state_q == S_R1) begin
			mem_addr = idx_nx[AW-1:0];
		end else begin
			mem_addr = i_q;
		end
		if (state_q == S_BSTART) begin
			wr_data = sat32(wf_ext);
		end else if (state_q == S_BDV) begin
			wr_data = sat32(q_ext);
		end else begin
			wr_data = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			quad_q        <= '0;
			lin_q         <= LIN_RESET;
			ofs_q         <= '0;
			min_q         <= '0;
			max_q         <= '0;
			entry_count_q <= '0;
			table_ready_q <= 1'b0;
			cnt_q         <= '0;
			i_q           <= '0;
			w_q           <= '0;
			neg_seen_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_QUAD: quad_q <= cfg_data;
					CFG_LIN:  lin_q  <= cfg_data;
					CFG_OFS:  ofs_q  <= cfg_data;
					CFG_MIN:  min_q  <= cfg_data[15:0];
					CFG_MAX:  max_q  <= cfg_data[15:0];
					default: ;
				endcase
			end

			// Result register: set on load, cleared when the beat is taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						cnt_q      <= CW'(span + 17'd1);
						i_q        <= '0;
						w_q        <= min_q;
						neg_seen_q <= 1'b0;
						if (in_data.mode == MODE_BUILD) begin
							state_q <= cnt_bad ? S_OUT : S_BSTART;
						end else if (in_data.mode == MODE_FWD && in_range) begin
							state_q <= S_E0;
						end else if (in_data.mode == MODE_INV && in_range && idx_ok) begin
							state_q <= S_R0;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				S_E0:  state_q <= S_E1;
				S_E1:  state_q <= S_E2;
				S_E2:  state_q <= S_E3;
				S_E3:  state_q <= S_E4;
				S_E4:  state_q <= S_E5;
				S_E5:  state_q <= S_OUT;
				S_R0:  state_q <= S_R1;
				S_R1:  state_q <= S_R2;
				S_R2:  state_q <= S_R3;
				S_R3:  state_q <= S_R4;
				S_R4:  state_q <= S_OUT;
				S_BSTART: state_q <= a_zero ? S_BNEXT : S_BP;
				S_BP:  state_q <= S_BT0;
				S_BT0: state_q <= S_BT1;
				S_BT1: state_q <= S_BD;
				S_BD: begin
					if (acc_q[ACC_W-1]) begin
						neg_seen_q <= 1'b1;
						state_q    <= S_BNEXT;
					end else begin
						state_q <= S_BSQ;
					end
				end
				S_BSQ: begin
					if (sq_done) begin
						state_q <= S_BDV;
					end
				end
				S_BDV: begin
					if (dv_done) begin
						state_q <= S_BNEXT;
					end
				end
				S_BNEXT: begin
					if (last_entry) begin
						entry_count_q <= cnt_q;
						table_ready_q <= 1'b1;
						state_q       <= S_OUT;
					end else begin
						i_q     <= i_q + 1'b1;
						w_q     <= w_q + 16'd1;
						state_q <= S_BSTART;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_x * mul_y;
		if (out_load) begin
			out_q.wave_out <= res_q;
			out_q.status   <= status_q;
		end
		unique case (state_q)
			S_IDLE: begin
				win_q  <= in_data.wave_in;
				idx_q  <= idx_w;
				frac_q <= frac_w;
				if (in_data.mode == MODE_BUILD) begin
					res_q    <= '0;
					status_q <= ST_BADCNT;
				end else begin
					res_q    <= in_data.wave_in;
					status_q <= ST_PASS;
				end
			end
			S_E1: aw_q <= prod_q[63:0];
			S_E2: acc_q <= (prod_ext <<< (6 + FRAC_BITS)) + (c_ext <<< (30 + FRAC_BITS));
			S_E3: acc_q <= acc_q + prod_ext;
			S_E4: acc_q <= acc_q + (prod_ext <<< 32);
			S_E5: begin
				res_q    <= sat32(acc_q >>> (30 + FRAC_BITS));
				status_q <= ST_OK;
			end
			S_R1: y0_q <= rd_q;
			S_R2: dy_q <= $signed({rd_q[31], rd_q}) - $signed({y0_q[31], y0_q});
			S_R4: begin
				res_q    <= sat32(v_ext);
				status_q <= ST_OK;
			end
			// discriminant: (b*b << 6) - (a*(c - w) << (26 - FRAC_BITS))
			S_BSTART: cmw_q <= {{32{ofs_q[31]}}, ofs_q} - wf64;
			S_BP:  acc_q <= prod_ext <<< 6;
			S_BT0: acc_q <= acc_q - (prod_ext <<< (26 - FRAC_BITS));
			S_BT1: acc_q <= acc_q - (prod_ext <<< (58 - FRAC_BITS));
			S_BSQ: begin
				if (sq_done) begin
					nneg_q <= n_sh[NW-1];
				end
			end
			S_BNEXT: begin
				if (last_entry) begin
					res_q    <= '0;
					status_q <= neg_seen_q ? ST_NEGDISC : ST_OK;
				end
			end
			default: ;
		endcase
	end

	// Square root of the discriminant
	qwc_isqrt #(
		.RAD_W(SQ_W)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.radicand(acc_q[SQ_W-1:0]),
		.done    (sq_done),
		.root    (sq_root)
	);

	// Division by 2a (the factor 2 is folded into the numerator scale)
	qwc_udiv #(
		.NUM_W(NW),
		.DEN_W(32)
	) u_udiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dv_start),
		.numer (n_mag),
		.denom (a_mag),
		.done  (dv_done),
		.quot  (dv_quo)
	);
endmodule

// ===== rtl/qwc_checker.sv =====
// Port-level checker of the wavelength calibration unit and its bind
`include "quadratic_wavelength_calibration_unit_defines.svh"

module qwc_port_checker import qwc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);
	logic err_beat;

	// Result beat that reports a rebuild error
	assign err_beat = out_valid
		&& (out_data.status == ST_BADCNT || out_data.status == ST_NEGDISC);

	// A stalled result beat holds
	`QWC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

	// An accepted item keeps the unit busy for at least the next cycle
	`QWC_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_valid && !in_stall, in_stall)

	// Rebuild errors always report a zero wavelength
	`QWC_ASSERT_IMP(a_err_zero, clk, arst_n, err_beat, out_data.wave_out == '0)

	// A fresh result beat leaves the input side free to take the next item
	`QWC_ASSERT_IMP(a_rise_idle, clk, arst_n, $rose(out_valid), !in_stall)
endmodule

bind quadratic_wavelength_calibration_unit qwc_port_checker u_qwc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);

// ===== verif/qwc_checker.sv =====
// Channel monitor, calibration predictor and result comparison for the calibration unit
module qwc_checker import qwc_pkg::*; #(
	parameter int TABLE_DEPTH = 2048,
	parameter int FRAC_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fails,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [127:0] wide_t;

	// Shadow copy of registers and table state
	logic [31:0] coef_a, coef_b, coef_c;
	logic [15:0] wave_lo, wave_hi;
	logic [31:0] inv_tbl [TABLE_DEPTH];
	int unsigned tbl_count;
	logic        tbl_ready;

	out_item_t   expected_beats[$];
	int          mismatch_count;

	function automatic logic [31:0] clamp32(input wide_t v);
		if (v > wide_t'(32'sh7FFF_FFFF)) begin
			return 32'h7FFF_FFFF;
		end else if (v < -wide_t'(64'sd2147483648)) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// Floor square root of a nonnegative 128-bit value
	function automatic logic [63:0] floor_sqrt(input logic [127:0] d);
		logic [63:0]  r;
		logic [63:0]  t;
		logic [127:0] sq;
		r = '0;
		for (int bit_n = 63; bit_n >= 0; bit_n--) begin
			t = r | (64'd1 << bit_n);
			sq = {64'd0, t} * {64'd0, t};
			if (sq <= d) r = t;
		end
		return r;
	endfunction

	// One table entry: positive root of a*x^2 + b*x + c = w
	function automatic logic [31:0] inverse_entry(input logic [15:0] w, inout logic neg);
		wide_t a, b, c, wf, p, t, d, n;
		a = wide_t'($signed(coef_a));
		b = wide_t'($signed(coef_b));
		c = wide_t'($signed(coef_c));
		wf = wide_t'({112'd0, w}) <<< FRAC_BITS;
		if (a == 0) return clamp32(wf);
		p = (b * b) <<< 6;
		t = (a * (c - wf)) <<< (26 - FRAC_BITS);
		d = p - t;
		if (d < 0) begin
			neg = 1'b1;
			return 32'd0;
		end
		n = wide_t'({64'd0, floor_sqrt(d)}) - b * 8;
		n = n <<< (FRAC_BITS + 2);
		return clamp32(n / a);
	endfunction

	function automatic out_item_t predict_calibration(input in_item_t beat);
		out_item_t res;
		wide_t     a, b, c, w, lo, hi, sum, diff, idx, frac, y0, y1, v, scale;
		int        count;
		logic      neg;
		logic      in_rng;
		a = wide_t'($signed(coef_a));
		b = wide_t'($signed(coef_b));
		c = wide_t'($signed(coef_c));
		w = wide_t'(beat.wave_in);
		lo = wide_t'({112'd0, wave_lo}) <<< FRAC_BITS;
		hi = wide_t'({112'd0, wave_hi}) <<< FRAC_BITS;
		scale = wide_t'(1) <<< FRAC_BITS;
		in_rng = tbl_ready && w >= lo && w <= hi;
		res.wave_out = beat.wave_in;
		res.status = ST_PASS;
		neg = 1'b0;
		if (beat.mode == MODE_BUILD) begin
			count = int'(wave_hi) - int'(wave_lo) + 1;
			res.wave_out = '0;
			if (count < 1 || count > TABLE_DEPTH) begin
				res.status = ST_BADCNT;
			end else begin
				for (int i = 0; i < count; i++)
					inv_tbl[i] = inverse_entry(wave_lo + 16'(i), neg);
				tbl_count = count;
				tbl_ready = 1'b1;
				res.status = neg ? ST_NEGDISC : ST_OK;
			end
		end else if (beat.mode == MODE_FWD && in_rng) begin
			sum = a * w * w + ((b * w) <<< (6 + FRAC_BITS)) + (c <<< (30 + FRAC_BITS));
			res.wave_out = clamp32(sum >>> (30 + FRAC_BITS));
			res.status = ST_OK;
		end else if (beat.mode == MODE_INV && in_rng) begin
			diff = w - lo;
			idx = diff >>> FRAC_BITS;
			frac = diff - (idx <<< FRAC_BITS);
			if (idx < wide_t'(tbl_count) - 1 && idx + 1 < TABLE_DEPTH) begin
				y0 = wide_t'($signed(inv_tbl[idx]));
				y1 = wide_t'($signed(inv_tbl[idx + 1]));
				v = y0 + (frac * (y1 - y0)) / scale;
				res.wave_out = clamp32(v);
				res.status = ST_OK;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Monitor: compare result beats, then predict accepted input beats
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			coef_a = '0;
			coef_b = LIN_RESET;
			coef_c = '0;
			wave_lo = '0;
			wave_hi = '0;
			tbl_count = 0;
			tbl_ready = 1'b0;
			expected_beats.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected beat", out_data.wave_out, '0);
				end else begin
					want = expected_beats.pop_front();
					if (out_data.wave_out !== want.wave_out)
						report_mismatch("wave_out", out_data.wave_out, want.wave_out);
					if (out_data.status !== want.status)
						report_mismatch("status", 32'(out_data.status), 32'(want.status));
				end
			end
			if (in_valid && !in_stall)
				expected_beats.push_back(predict_calibration(in_data));
			if (cfg_we) begin
				case (cfg_index)
					CFG_QUAD: coef_a = cfg_data;
					CFG_LIN:  coef_b = cfg_data;
					CFG_OFS:  coef_c = cfg_data;
					CFG_MIN:  wave_lo = cfg_data[15:0];
					CFG_MAX:  wave_hi = cfg_data[15:0];
					default: ;
				endcase
			end
			pending <= expected_beats.size();
		end
	end

	initial mismatch_count = 0;
	assign fails = mismatch_count;
endmodule

// ===== verif/tb.sv =====
// Stimulus, receiver stalls and verdict for the calibration unit
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qwc_pkg::*;

	localparam logic [1:0] MODE_NONE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          fails;
	int          pending;

	logic [15:0] cur_lo, cur_hi;
	int          burst_left;
	logic        hold_go;

	quadratic_wavelength_calibration_unit dut (.*);

	qwc_checker mon (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// One register write; the caller drops the enable after the last one
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_cal(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
			input logic [15:0] lo, input logic [15:0] hi);
		write_reg(CFG_QUAD, a);
		write_reg(CFG_LIN, b);
		write_reg(CFG_OFS, c);
		write_reg(CFG_MIN, {16'd0, lo});
		write_reg(CFG_MAX, {16'd0, hi});
		cfg_we <= 1'b0;
		cur_lo = lo;
		cur_hi = hi;
		@(posedge clk);
	endtask

	// Sender: bursts of beats with random gaps
	task automatic send_beat(input logic [1:0] mode, input logic [31:0] w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 14);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= {mode, w};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Let every outstanding result come back before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_wave();
		longint lo, hi;
		int     r;
		lo = longint'(cur_lo) <<< 16;
		hi = longint'(cur_hi) <<< 16;
		r = $urandom_range(0, 19);
		if (r == 0) return $urandom;
		if (r == 1) return 32'(lo - $urandom_range(1, 70000));
		if (r == 2) return 32'(hi + $urandom_range(1, 70000));
		if (r == 3) return 32'(hi);
		if (hi < lo) return 32'(lo + $urandom_range(0, 200000));
		return 32'(lo + $urandom_range(0, 32'(hi - lo)));
	endfunction

	// Receiver: stall pattern, plus one long hold-off once random traffic runs
	initial begin
		int  kind, len;
		bit  held;
		out_stall = 1'b0;
		held = 0;
		forever begin
			kind = $urandom_range(0, 4);
			len = $urandom_range(10, 60);
			if (hold_go && !held) begin
				held = 1;
				out_stall <= 1'b1;
				repeat (6000) @(posedge clk);
			end else begin
				repeat (len) begin
					out_stall <= (kind == 0) ? 1'b0 : ($urandom_range(0, 99) < 35);
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		#60ms;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [31:0] a, b, c;
		logic [15:0] lo, hi;
		int          r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_QUAD;
		cfg_data = '0;
		cur_lo = '0;
		cur_hi = '0;
		burst_left = 0;
		hold_go = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No table yet: the first three beats pass through, and the build makes a one-entry table
		send_beat(MODE_FWD, 32'h0000_0000);
		send_beat(MODE_INV, 32'h0000_0000);
		send_beat(MODE_NONE, 32'h1234_5678);
		send_beat(MODE_BUILD, 32'hFFFF_FFFF);
		drain();

		// Linear calibration, table equals the wavelength
		set_cal(32'd0, LIN_RESET, 32'h0001_8000, 16'd10, 16'd20);
		send_beat(MODE_BUILD, 32'd0);
		send_beat(MODE_INV, 32'h000A_0000);
		send_beat(MODE_INV, 32'h000F_8000);
		send_beat(MODE_INV, 32'h0014_0000);
		send_beat(MODE_INV, 32'h0009_FFFF);
		send_beat(MODE_FWD, 32'h0014_0001);
		send_beat(MODE_FWD, 32'h000C_4000);
		drain();

		// Full-depth table with curvature
		set_cal(32'h0010_0000, LIN_RESET, 32'h0000_0000, 16'd0, 16'd2047);
		send_beat(MODE_BUILD, 32'd0);
		send_beat(MODE_INV, 32'h07FE_8000);
		send_beat(MODE_INV, 32'h0100_1234);
		drain();

		// Bad counts: empty range and one past the depth
		set_cal(32'h0010_0000, LIN_RESET, 32'd0, 16'd100, 16'd99);
		send_beat(MODE_BUILD, 32'd0);
		drain();
		set_cal(32'h0010_0000, LIN_RESET, 32'd0, 16'd0, 16'd2048);
		send_beat(MODE_BUILD, 32'd0);
		drain();

		// Negative discriminant
		set_cal(32'h8000_0000, 32'd0, 32'd0, 16'd1, 16'd3);
		send_beat(MODE_BUILD, 32'd0);
		send_beat(MODE_INV, 32'h0001_8000);
		drain();

		// Register and field extremes, saturating evaluation
		set_cal(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd65534, 16'd65535);
		send_beat(MODE_BUILD, 32'd0);
		send_beat(MODE_FWD, 32'h7FFF_FFFF);
		send_beat(MODE_FWD, 32'h8000_0000);
		drain();
		set_cal(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd5);
		send_beat(MODE_BUILD, 32'd0);
		send_beat(MODE_FWD, 32'h0005_0000);
		send_beat(MODE_INV, 32'h0002_C000);
		drain();

		// Random phases
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 2))
				0: begin
					a = 32'($urandom_range(0, 1 << 19)) - (32'd1 << 18);
					b = LIN_RESET + 32'($urandom_range(0, 1 << 22)) - (32'd1 << 21);
					c = ((32'($urandom_range(0, 40)) - 32'd20) << 16) | $urandom_range(0, 65535);
					lo = 16'($urandom_range(0, 30000));
					hi = lo + 16'($urandom_range(0, 40));
				end
				1: begin
					a = $urandom;
					b = $urandom;
					c = $urandom;
					lo = 16'($urandom);
					r = $urandom_range(0, 4);
					hi = (r == 0) ? lo - 16'($urandom_range(1, 50)) : lo + 16'($urandom_range(0, 20));
				end
				default: begin
					a = 32'd0;
					b = $urandom;
					c = $urandom;
					lo = 16'($urandom_range(0, 32000));
					hi = lo + 16'($urandom_range(0, 64));
				end
			endcase
			set_cal(a, b, c, lo, hi);
			send_beat(MODE_BUILD, $urandom);
			for (int k = 0; k < 100; k++) begin
				// long hold-off starts once the first rebuild is behind us
				if (ph == 0 && k == 10) hold_go = 1'b1;
				r = $urandom_range(0, 99);
				if (r < 45) send_beat(MODE_INV, pick_wave());
				else if (r < 88) send_beat(MODE_FWD, pick_wave());
				else if (r < 94) send_beat(MODE_BUILD, $urandom);
				else send_beat(MODE_NONE, pick_wave());
			end
			drain();
		end

		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/qwc_pkg.sv
rtl/qwc_isqrt.sv
rtl/qwc_udiv.sv
rtl/quadratic_wavelength_calibration_unit.sv
rtl/qwc_checker.sv
verif/qwc_checker.sv
verif/tb.sv
